// ----- src/utf8vr_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// utf8vr_pkg: shared types and constants of the UTF-8 validate and repair block
// Byte codes of strict UTF-8 decoding, the replacement sequence and the
// description of one pending output burst handed from scanner to emitter.
// ============================================================================
package utf8vr_pkg;

    localparam logic [7:0] REPL_B0   = 8'hEF;
    localparam logic [7:0] REPL_B1   = 8'hBF;
    localparam logic [7:0] REPL_B2   = 8'hBD;

    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_SUR = 8'hED;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;

    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] CONT_HI   = 8'hBF;
    localparam logic [7:0] E0_LO     = 8'hA0;
    localparam logic [7:0] ED_HI     = 8'h9F;
    localparam logic [7:0] F0_LO     = 8'h90;
    localparam logic [7:0] F4_HI     = 8'h8F;

    localparam logic [1:0] SUB_LAST  = 2'd2;

    typedef struct packed {
        logic [2:0]      rep_cnt;
        logic [2:0]      plain_cnt;
        logic [3:0]      total;
        logic [3:0][7:0] plain;
        logic            last;
        logic            str_valid;
    } t_job;

    function automatic logic [7:0] repl_byte(input logic [1:0] sub);
        logic [7:0] res;
        unique case (sub)
            2'd0:    res = REPL_B0;
            2'd1:    res = REPL_B1;
            default: res = REPL_B2;
        endcase
        return res;
    endfunction

endpackage

// ----- src/utf8_validate_and_repair.sv -----
`timescale 1ns / 1ps
// ============================================================================
// utf8_validate_and_repair: streaming strict UTF-8 checker with repair
// Passes well-formed UTF-8 through and replaces each bad byte with EF BF BD.
// ============================================================================
// Usage:
// The input channel (i_valid, o_stall) takes one raw byte per word, with
// i_in_last set on the final byte of a string. The output channel (o_valid,
// i_stall) delivers the repaired string one byte per word; o_out_last marks
// its final byte, where o_string_valid tells whether no replacement occurred.
// Bytes of a multi-byte sequence are held until the sequence completes or
// breaks, so an input word releases between zero and twelve output words.
// The first byte that a word releases passes the burst register and then the
// output register. Input words that release at most one output word are taken
// in every cycle while the receiver does not stall; a word that releases more
// words holds the serialiser, with o_stall high until its last word is emitted.
// When the receiver stalls, the output word holds and the serialiser waits;
// the next input word is still taken while the final word of a burst sits in
// the output register. Reset clears any open sequence, the error flag and
// all valid flags; no clearing pass is needed.
// ============================================================================
module utf8_validate_and_repair (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_is_replacement,
    output logic       o_out_last,
    output logic       o_string_valid
);

    utf8vr_pkg::t_job job;
    logic             job_load;
    logic             busy;
    logic             take;

    assign o_stall = busy;
    assign take    = i_valid && !busy;

    utf8vr_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_byte     (i_in_byte),
        .i_last     (i_in_last),
        .o_job      (job),
        .o_job_load (job_load)
    );

    utf8vr_emit u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (job_load),
        .i_job            (job),
        .i_stall          (i_stall),
        .o_busy           (busy),
        .o_valid          (o_valid),
        .o_out_byte       (o_out_byte),
        .o_is_replacement (o_is_replacement),
        .o_out_last       (o_out_last),
        .o_string_valid   (o_string_valid)
    );

endmodule

// ----- src/utf8vr_scan.sv -----
`timescale 1ns / 1ps
// ============================================================================
// utf8vr_scan: sequence tracker and burst decoder
// Holds the open multi-byte sequence and decides, for each accepted word,
// how many replacements and which plain bytes it releases.
// ============================================================================
module utf8vr_scan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output utf8vr_pkg::t_job  o_job,
    output logic              o_job_load
);

    logic [7:0] r_pend [3];
    logic [1:0] r_pend_cnt, n_pend_cnt;
    logic [2:0] r_seq_len, n_seq_len;
    logic [7:0] r_lo, n_lo;
    logic [7:0] r_hi, n_hi;
    logic       r_err, n_err;

    logic       in_seq, ok, complete, extend, consumed;
    logic       ascii, lead_open, lead_rep;
    logic [2:0] lead_len;
    logic [7:0] lead_lo, lead_hi;
    logic [2:0] cnt_inc, flush_k, rep_k, plain_m;
    logic       err_next;

    always_comb begin
        lead_len = 3'd0;
        lead_lo  = utf8vr_pkg::CONT_LO;
        lead_hi  = utf8vr_pkg::CONT_HI;
        if (i_byte >= utf8vr_pkg::LEAD2_LO && i_byte <= utf8vr_pkg::LEAD2_HI) begin
            lead_len = 3'd2;
        end else if (i_byte >= utf8vr_pkg::LEAD3_LO && i_byte <= utf8vr_pkg::LEAD3_HI) begin
            lead_len = 3'd3;
            if (i_byte == utf8vr_pkg::LEAD3_LO) begin
                lead_lo = utf8vr_pkg::E0_LO;
            end else if (i_byte == utf8vr_pkg::LEAD3_SUR) begin
                lead_hi = utf8vr_pkg::ED_HI;
            end
        end else if (i_byte >= utf8vr_pkg::LEAD4_LO && i_byte <= utf8vr_pkg::LEAD4_HI) begin
            lead_len = 3'd4;
            if (i_byte == utf8vr_pkg::LEAD4_LO) begin
                lead_lo = utf8vr_pkg::F0_LO;
            end else if (i_byte == utf8vr_pkg::LEAD4_HI) begin
                lead_hi = utf8vr_pkg::F4_HI;
            end
        end
    end

    always_comb begin
        cnt_inc  = {1'b0, r_pend_cnt} + 3'd1;
        in_seq   = (r_seq_len != 3'd0) && (r_pend_cnt != 2'd0);
        ok       = (r_pend_cnt == 2'd1) ? (i_byte >= r_lo && i_byte <= r_hi)
                                        : (i_byte[7:6] == 2'b10);
        complete = in_seq && ok && (cnt_inc == r_seq_len);
        extend   = in_seq && ok && !complete && (r_pend_cnt != 2'd3);
        consumed = complete || extend;
        flush_k  = (r_seq_len != 3'd0 && !consumed) ? {1'b0, r_pend_cnt} : 3'd0;

        ascii     = (i_byte != 8'h00) && !i_byte[7];
        lead_open = !consumed && (lead_len != 3'd0) && !i_last;
        lead_rep  = !consumed && !ascii && !lead_open;

        if (complete) begin
            rep_k = 3'd0;
        end else if (extend) begin
            rep_k = i_last ? cnt_inc : 3'd0;
        end else begin
            rep_k = flush_k + {2'b00, lead_rep};
        end

        if (complete) begin
            plain_m = cnt_inc;
        end else if (!consumed && ascii) begin
            plain_m = 3'd1;
        end else begin
            plain_m = 3'd0;
        end

        err_next = r_err || (rep_k != 3'd0);

        o_job.rep_cnt   = rep_k;
        o_job.plain_cnt = plain_m;
        o_job.total     = {rep_k, 1'b0} + {1'b0, rep_k} + {1'b0, plain_m};
        o_job.plain[0]  = (complete && r_pend_cnt > 2'd0) ? r_pend[0] : i_byte;
        o_job.plain[1]  = (complete && r_pend_cnt > 2'd1) ? r_pend[1] : i_byte;
        o_job.plain[2]  = (complete && r_pend_cnt > 2'd2) ? r_pend[2] : i_byte;
        o_job.plain[3]  = i_byte;
        o_job.last      = i_last;
        o_job.str_valid = !err_next;
        o_job_load      = i_take && (o_job.total != 4'd0);
    end

    always_comb begin
        n_pend_cnt = r_pend_cnt;
        n_seq_len  = r_seq_len;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_err      = err_next;
        if (!extend) begin
            n_pend_cnt = 2'd0;
            n_seq_len  = 3'd0;
            n_lo       = utf8vr_pkg::CONT_LO;
            n_hi       = utf8vr_pkg::CONT_HI;
        end else begin
            n_pend_cnt = cnt_inc[1:0];
        end
        if (lead_open) begin
            n_pend_cnt = 2'd1;
            n_seq_len  = lead_len;
            n_lo       = lead_lo;
            n_hi       = lead_hi;
        end
        if (i_last) begin
            n_pend_cnt = 2'd0;
            n_seq_len  = 3'd0;
            n_lo       = utf8vr_pkg::CONT_LO;
            n_hi       = utf8vr_pkg::CONT_HI;
            n_err      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= 2'd0;
            r_seq_len  <= 3'd0;
            r_lo       <= utf8vr_pkg::CONT_LO;
            r_hi       <= utf8vr_pkg::CONT_HI;
            r_err      <= 1'b0;
        end else if (i_take) begin
            r_pend_cnt <= n_pend_cnt;
            r_seq_len  <= n_seq_len;
            r_lo       <= n_lo;
            r_hi       <= n_hi;
            r_err      <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && lead_open) begin
            r_pend[0] <= i_byte;
        end else if (i_take && extend) begin
            r_pend[r_pend_cnt] <= i_byte;
        end
    end

`ifndef SYNTH
    a_seq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq_len != 3'd0) |-> (r_pend_cnt != 2'd0 && {1'b0, r_pend_cnt} < r_seq_len))
        else $error("open sequence holds an impossible byte count");
`endif

endmodule

// ----- src/utf8vr_emit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// utf8vr_emit: burst serialiser with output register
// Plays out one burst of replacement and plain bytes, one word per cycle when
// not stalled by the receiver, into a registered output that holds in a stall.
// ============================================================================
module utf8vr_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  utf8vr_pkg::t_job  i_job,
    input  logic              i_stall,
    output logic              o_busy,
    output logic              o_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_is_replacement,
    output logic              o_out_last,
    output logic              o_string_valid
);

    utf8vr_pkg::t_job r_job;
    logic       r_job_valid;
    logic [3:0] r_remain;
    logic [2:0] r_rep_left;
    logic [1:0] r_sub;
    logic [1:0] r_pidx;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_rep;
    logic       r_out_last;
    logic       r_out_sv;

    logic       emit, finish, is_rep;
    logic [7:0] sel_byte;

    always_comb begin
        emit     = r_job_valid && (!r_out_valid || !i_stall);
        finish   = emit && (r_remain == 4'd1);
        is_rep   = (r_rep_left != 3'd0);
        sel_byte = is_rep ? utf8vr_pkg::repl_byte(r_sub) : r_job.plain[r_pidx];
        o_busy   = r_job_valid && !finish;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_remain    <= 4'd0;
            r_rep_left  <= 3'd0;
            r_sub       <= 2'd0;
            r_pidx      <= 2'd0;
        end else if (i_load) begin
            r_job_valid <= 1'b1;
            r_remain    <= i_job.total;
            r_rep_left  <= i_job.rep_cnt;
            r_sub       <= 2'd0;
            r_pidx      <= 2'd0;
        end else if (emit) begin
            r_job_valid <= !finish;
            r_remain    <= r_remain - 4'd1;
            if (is_rep) begin
                if (r_sub == utf8vr_pkg::SUB_LAST) begin
                    r_sub      <= 2'd0;
                    r_rep_left <= r_rep_left - 3'd1;
                end else begin
                    r_sub <= r_sub + 2'd1;
                end
            end else begin
                r_pidx <= r_pidx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= sel_byte;
            r_out_rep  <= is_rep;
            r_out_last <= r_job.last && (r_remain == 4'd1);
            r_out_sv   <= r_job.last && (r_remain == 4'd1) && r_job.str_valid;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_is_replacement = r_out_rep;
    assign o_out_last       = r_out_last;
    assign o_string_valid   = r_out_sv;

`ifndef SYNTH
    a_remain_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_remain != 4'd0))
        else $error("live burst has nothing left to send");

    a_plain_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_job_valid && r_rep_left == 3'd0)
            |-> (r_remain == ({1'b0, r_job.plain_cnt} - {2'b00, r_pidx})))
        else $error("plain byte count out of step with remaining count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_job_valid || finish))
        else $error("new burst loaded over an unfinished one");

    a_valid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sv) |-> (r_out_last && !r_out_rep))
        else $error("string reported valid on a replacement or inner word");
`endif

endmodule

// ----- tb/sv/utf8_repair_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// utf8_repair_checker: scoreboard for the UTF-8 validate and repair block
// Watches both channels, works out the repaired bytes that each accepted input
// word releases, and compares every accepted output word with the oldest one.
// ============================================================================
module utf8_repair_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_is_repl,
    input  logic       i_out_last,
    input  logic       i_out_str_valid,
    output int         o_fail_count,
    output int         o_outstanding
);

    typedef struct packed {
        logic [7:0] value;
        logic       repl;
        logic       eos;
        logic       ok;
    } t_repaired_byte;

    t_repaired_byte expected_q[$];

    logic [7:0] held [3];
    int         held_cnt;
    int         seq_len;
    logic [7:0] second_lo;
    logic [7:0] second_hi;
    logic       err_flag;
    int         fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic void add_out(input logic [7:0] b, input logic rep);
        expected_q.push_back('{b, rep, 1'b0, 1'b0});
    endfunction

    function automatic void add_replacement();
        add_out(utf8vr_pkg::REPL_B0, 1'b1);
        add_out(utf8vr_pkg::REPL_B1, 1'b1);
        add_out(utf8vr_pkg::REPL_B2, 1'b1);
        err_flag = 1'b1;
    endfunction

    function automatic void clear_sequence();
        held_cnt  = 0;
        seq_len   = 0;
        second_lo = utf8vr_pkg::CONT_LO;
        second_hi = utf8vr_pkg::CONT_HI;
    endfunction

    function automatic void drop_held();
        for (int k = 0; k < held_cnt; k++) begin
            add_replacement();
        end
        clear_sequence();
    endfunction

    function automatic void open_or_pass(input logic [7:0] b, input logic fin);
        int         len;
        logic [7:0] lo;
        logic [7:0] hi;
        len = 0;
        lo  = utf8vr_pkg::CONT_LO;
        hi  = utf8vr_pkg::CONT_HI;
        if (b == '0) begin
            add_replacement();
            return;
        end
        if (b < utf8vr_pkg::CONT_LO) begin
            add_out(b, 1'b0);
            return;
        end
        if (b >= utf8vr_pkg::LEAD2_LO && b <= utf8vr_pkg::LEAD2_HI) begin
            len = 2;
        end else if (b >= utf8vr_pkg::LEAD3_LO && b <= utf8vr_pkg::LEAD3_HI) begin
            len = 3;
            if (b == utf8vr_pkg::LEAD3_LO) begin
                lo = utf8vr_pkg::E0_LO;
            end else if (b == utf8vr_pkg::LEAD3_SUR) begin
                hi = utf8vr_pkg::ED_HI;
            end
        end else if (b >= utf8vr_pkg::LEAD4_LO && b <= utf8vr_pkg::LEAD4_HI) begin
            len = 4;
            if (b == utf8vr_pkg::LEAD4_LO) begin
                lo = utf8vr_pkg::F0_LO;
            end else if (b == utf8vr_pkg::LEAD4_HI) begin
                hi = utf8vr_pkg::F4_HI;
            end
        end
        if (len == 0 || fin) begin
            add_replacement();
            return;
        end
        held[0]   = b;
        held_cnt  = 1;
        seq_len   = len;
        second_lo = lo;
        second_hi = hi;
    endfunction

    function automatic void predict_word(input logic [7:0] b, input logic fin);
        logic           taken;
        logic           fits;
        t_repaired_byte tail;
        taken = 1'b0;
        if (seq_len != 0) begin
            if (held_cnt == 1) begin
                fits = (b >= second_lo && b <= second_hi);
            end else begin
                fits = (b >= utf8vr_pkg::CONT_LO && b <= utf8vr_pkg::CONT_HI);
            end
            if (!fits) begin
                drop_held();
            end else begin
                taken = 1'b1;
                if (held_cnt + 1 == seq_len) begin
                    for (int k = 0; k < held_cnt; k++) begin
                        add_out(held[k], 1'b0);
                    end
                    add_out(b, 1'b0);
                    clear_sequence();
                end else begin
                    held[held_cnt] = b;
                    held_cnt++;
                    if (fin) begin
                        drop_held();
                    end
                end
            end
        end
        if (!taken) begin
            open_or_pass(b, fin);
        end
        if (fin) begin
            // The final word of a string always releases at least one byte.
            tail     = expected_q.pop_back();
            tail.eos = 1'b1;
            tail.ok  = !err_flag;
            expected_q.push_back(tail);
            err_flag = 1'b0;
            clear_sequence();
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want_v,
                                        input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %02h, got %02h", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_repaired_byte want;
        if (!i_rst_n) begin
            expected_q.delete();
            clear_sequence();
            err_flag = 1'b0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predict_word(i_in_byte, i_in_last);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected output word: out_byte %02h", i_out_byte);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("out_byte", want.value, i_out_byte);
                    check_field("is_replacement", {7'd0, want.repl}, {7'd0, i_out_is_repl});
                    check_field("out_last", {7'd0, want.eos}, {7'd0, i_out_last});
                    check_field("string_valid", {7'd0, want.ok}, {7'd0, i_out_str_valid});
                end
            end
        end
        o_outstanding = expected_q.size();
    end

endmodule

// ----- tb/sv/tb_utf8_validate_and_repair.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_utf8_validate_and_repair: testbench top of the UTF-8 validate and repair block
// Drives byte strings into the block, first a directed set of boundary and
// broken sequences, then mostly well-formed random text with some corruption,
// with random idling on both sides, and gives the verdict from the checker.
// ============================================================================
module tb_utf8_validate_and_repair;

    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_HOLD    = 200;
    localparam int LONG_HOLD_AT = 300;
    localparam int RANDOM_WORDS = 500;
    localparam int DRAIN_STRING = 20;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       out_repl;
    logic       out_last;
    logic       out_ok;

    int         fail_count;
    int         outstanding;
    int         sent_words = 0;
    int         idle_cycles = 0;
    bit         calm = 1'b0;
    logic [7:0] text_q[$];

    utf8_validate_and_repair dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_stall          (in_stall),
        .i_in_byte        (in_byte),
        .i_in_last        (in_last),
        .o_valid          (out_valid),
        .i_stall          (out_stall),
        .o_out_byte       (out_byte),
        .o_is_replacement (out_repl),
        .o_out_last       (out_last),
        .o_string_valid   (out_ok)
    );

    utf8_repair_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_byte       (in_byte),
        .i_in_last       (in_last),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_byte      (out_byte),
        .i_out_is_repl   (out_repl),
        .i_out_last      (out_last),
        .i_out_str_valid (out_ok),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("** utf8_validate_and_repair: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input logic [7:0] b, input logic fin, input bit drain_first);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0 || drain_first) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            if (drain_first) begin
                do @(negedge clk); while (outstanding != 0);
            end
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= fin;
        do @(posedge clk); while (in_stall);
        sent_words++;
        @(negedge clk);
    endtask

    task automatic send_string(input bit drain_first);
        for (int k = 0; k < text_q.size(); k++) begin
            send_word(text_q[k], k == text_q.size() - 1, drain_first && k == 0);
        end
    endtask

    task automatic add_char(input bit noisy);
        logic [7:0] seq[$];
        logic [7:0] lead;
        logic [7:0] lo;
        logic [7:0] hi;
        int         len;
        int         kind;
        int         pos;
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            if ($urandom_range(0, 19) == 0) begin
                seq.push_back(8'h00);
            end else begin
                seq.push_back(8'($urandom_range(1, 127)));
            end
        end else begin
            if (kind < 6) begin
                lead = 8'($urandom_range(utf8vr_pkg::LEAD2_LO, utf8vr_pkg::LEAD2_HI));
                len  = 2;
            end else if (kind < 8) begin
                lead = 8'($urandom_range(utf8vr_pkg::LEAD3_LO, utf8vr_pkg::LEAD3_HI));
                len  = 3;
            end else begin
                lead = 8'($urandom_range(utf8vr_pkg::LEAD4_LO, utf8vr_pkg::LEAD4_HI));
                len  = 4;
            end
            lo = (lead == utf8vr_pkg::LEAD3_LO) ? utf8vr_pkg::E0_LO :
                 (lead == utf8vr_pkg::LEAD4_LO) ? utf8vr_pkg::F0_LO : utf8vr_pkg::CONT_LO;
            hi = (lead == utf8vr_pkg::LEAD3_SUR) ? utf8vr_pkg::ED_HI :
                 (lead == utf8vr_pkg::LEAD4_HI) ? utf8vr_pkg::F4_HI : utf8vr_pkg::CONT_HI;
            seq.push_back(lead);
            seq.push_back(8'($urandom_range(lo, hi)));
            repeat (len - 2) begin
                seq.push_back(8'($urandom_range(utf8vr_pkg::CONT_LO, utf8vr_pkg::CONT_HI)));
            end
        end
        if (noisy) begin
            pos = $urandom_range(0, seq.size() - 1);
            case ($urandom_range(0, 2))
                0: begin
                    seq[pos] = 8'($urandom_range(0, 255));
                end
                1: begin
                    while (seq.size() > pos + 1) void'(seq.pop_back());
                end
                default: begin
                    seq.insert(pos, 8'($urandom_range(0, 255)));
                end
            endcase
        end
        foreach (seq[k]) text_q.push_back(seq[k]);
    endtask

    // The receiver draws its own wait before every word and holds off once
    // for a long stretch so that the block fills up and stalls its input.
    initial begin
        int hold;
        int taken_words;
        out_stall   = 1'b0;
        taken_words = 0;
        @(posedge rst_n);
        forever begin
            if (taken_words == LONG_HOLD_AT) begin
                hold = LONG_HOLD;
            end else begin
                hold = calm ? 0 : $urandom_range(0, 11);
            end
            out_stall <= (hold > 0);
            repeat (hold) @(negedge clk);
            if (hold > 0) begin
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            taken_words++;
            @(negedge clk);
        end
    end

    initial begin
        in_valid = 1'b0;
        in_byte  = '0;
        in_last  = 1'b0;
        rst_n    = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // NUL, top of ASCII, an overlong lead, a stray continuation and an
        // invalid lead on the final byte.
        text_q = '{8'h00, 8'h7F, 8'hC1, 8'h80, 8'hFF};
        send_string(1'b0);
        // A complete pair, an overlong three-byte form and a lead on the final byte.
        text_q = '{8'hC2, 8'h80, 8'hE0, 8'h9F, 8'hED};
        send_string(1'b0);
        // Lowest three-byte form and the highest code point, ending the string.
        text_q = '{8'hE0, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string(1'b0);
        // Three held bytes broken by an invalid final byte.
        text_q = '{8'hF0, 8'h90, 8'h80, 8'hF5};
        send_string(1'b0);
        // A surrogate, then a sequence cut short by the end of the string.
        text_q = '{8'hED, 8'hA0, 8'hF0, 8'h90};
        send_string(1'b0);

        for (int s = 0; sent_words < RANDOM_WORDS + 25; s++) begin
            text_q.delete();
            calm = (s % 7 == 3);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 8)) add_char($urandom_range(0, 5) == 0);
            end
            send_string(s == DRAIN_STRING);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (outstanding != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("** utf8_validate_and_repair: PASSED **");
        end else begin
            $display("** utf8_validate_and_repair: FAILED **");
        end
        $finish;
    end

endmodule
